### design/assert_macros.svh
// Assertion macros shared by the gyro integrator modules.
// Needs a clock named clk and a reset named rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge outside reset.
`define GQI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define GQI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/gqi_pkg.sv
// Types, constants and the row term table of the gyro quaternion integrator.
// No dependencies.
package gqi_pkg;

  localparam logic signed [31:0] ONE_Q30     = 32'sh4000_0000;
  localparam logic signed [31:0] NEG_ONE_Q30 = 32'shC000_0000;
  localparam logic [30:0]        ANGLE_LIMIT = 31'h1000_0000;
  localparam logic [30:0]        UNIT_LIMIT  = 31'h4000_0000;
  localparam logic [31:0]        ANGLE_DIV   = 32'd31250;
  localparam logic [63:0]        ANGLE_HALF  = 64'd15625;
  // floor(2^43 / 31250): the quotient estimate is (num >> 11) * ANGLE_RECIP >> 32.
  localparam logic [31:0]        ANGLE_RECIP = 32'd281474976;
  // Smallest rate-time product whose rounded half angle exceeds the limit.
  localparam logic [63:0]        ANGLE_SAT_PROD = 64'd8388608015625;

  // One queued item: the rates and the elapsed time since the last item.
  typedef struct packed {
    logic signed [31:0] rate_x;
    logic signed [31:0] rate_y;
    logic signed [31:0] rate_z;
    logic [31:0]        dt_us;
  } work_t;

  typedef struct packed {
    logic  valid;
    work_t work;
  } push_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // One product term of a row of (I + S) q.
  typedef struct packed {
    logic [1:0] ang_sel;
    logic [1:0] att_sel;
    logic       neg;
  } term_t;

  function automatic term_t row_term(input logic [1:0] row, input logic [1:0] term);
    term_t t;
    t = '{ang_sel: 2'd0, att_sel: 2'd0, neg: 1'b0};
    unique case ({row, term})
      4'b00_00: t = '{2'd0, 2'd1, 1'b1};
      4'b00_01: t = '{2'd1, 2'd2, 1'b1};
      4'b00_10: t = '{2'd2, 2'd3, 1'b1};
      4'b01_00: t = '{2'd0, 2'd0, 1'b0};
      4'b01_01: t = '{2'd2, 2'd2, 1'b0};
      4'b01_10: t = '{2'd1, 2'd3, 1'b1};
      4'b10_00: t = '{2'd1, 2'd0, 1'b0};
      4'b10_01: t = '{2'd2, 2'd1, 1'b1};
      4'b10_10: t = '{2'd0, 2'd3, 1'b0};
      4'b11_00: t = '{2'd2, 2'd0, 1'b0};
      4'b11_01: t = '{2'd1, 2'd1, 1'b0};
      4'b11_10: t = '{2'd0, 2'd2, 1'b1};
      default:  t = '{2'd0, 2'd0, 1'b0};
    endcase
    return t;
  endfunction

endpackage

### design/gqi_in_if.sv
// Sample channel: three rates and a timestamp with a valid/ready handshake.
// No dependencies.
interface gqi_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rate_x;
  logic signed [31:0] rate_y;
  logic signed [31:0] rate_z;
  logic [31:0]        sample_time_us;

  modport source(output valid, rate_x, rate_y, rate_z, sample_time_us, input ready);
  modport sink(input valid, rate_x, rate_y, rate_z, sample_time_us, output ready);
endinterface

### design/gqi_out_if.sv
// Result channel: the updated attitude quaternion with a valid/ready handshake.
// No dependencies.
interface gqi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] quat_w;
  logic signed [31:0] quat_x;
  logic signed [31:0] quat_y;
  logic signed [31:0] quat_z;

  modport source(output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink(input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

### design/gyro_quaternion_integrator.sv
// Top level of the gyro quaternion integrator: front end, queue, back end.
// Depends on gqi_pkg, gqi_in_if, gqi_out_if, gqi_front, gqi_queue, gqi_back.
//
//   channel  role  payload
//   sample   sink  rate_x, rate_y, rate_z, sample_time_us
//   result   src   quat_w, quat_x, quat_y, quat_z
//
// The back end works on one item at a time, mostly in the shared restoring
// divider (31 steps per division, four divisions, none when the norm is zero)
// and the 32-step square root; each half angle passes five states in turn.
// The front takes an item whenever the two-entry queue has room, so up to two
// items wait while one is worked on.
// Synchronous reset restores the identity attitude and a zero last timestamp.
// A stalled result holds the back end in its final state until it is taken.
module gyro_quaternion_integrator (
  input logic       clk,
  input logic       rst,
  gqi_in_if.sink    sample,
  gqi_out_if.source result
);
  import gqi_pkg::*;

  push_t   push;
  work_t   head;
  q_stat_t qs;
  logic    pop;

  gqi_front u_front (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .qs     (qs),
    .push   (push)
  );

  gqi_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .qs   (qs)
  );

  gqi_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .qs     (qs),
    .pop    (pop),
    .result (result)
  );
endmodule

### design/gqi_front.sv
// Front end: accepts samples, forms the wrapped time step, pushes work items.
// Depends on gqi_pkg and gqi_in_if.
module gqi_front (
  input  logic           clk,
  input  logic           rst,
  gqi_in_if.sink         sample,
  input  gqi_pkg::q_stat_t qs,
  output gqi_pkg::push_t push
);
  import gqi_pkg::*;

  logic [31:0] last_time;
  logic        take;

  assign sample.ready = !qs.full;
  assign take         = sample.valid && !qs.full;

  // Work item with the time step wrapping modulo 2^32.
  always_comb begin
    push.valid       = take;
    push.work.rate_x = sample.rate_x;
    push.work.rate_y = sample.rate_y;
    push.work.rate_z = sample.rate_z;
    push.work.dt_us  = sample.sample_time_us - last_time;
  end

  // The last timestamp follows every accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_time <= '0;
    end else if (take) begin
      last_time <= sample.sample_time_us;
    end
  end
endmodule

### design/gqi_queue.sv
// Two-entry queue of work items between the front and the back end.
// Depends on gqi_pkg and assert_macros.svh.
`include "assert_macros.svh"
module gqi_queue (
  input  logic             clk,
  input  logic             rst,
  input  gqi_pkg::push_t   push,
  input  logic             pop,
  output gqi_pkg::work_t   head,
  output gqi_pkg::q_stat_t qs
);
  import gqi_pkg::*;

  work_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign qs.empty = (count == 2'd0);
  assign qs.full  = (count == 2'd2);
  assign head     = slots[rd_ptr];

  // Storage is written at the tail only.
  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.work;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push.valid) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push.valid} - {1'b0, pop};
    end
  end

  `GQI_ASSERT(a_no_push_full, qs.full |-> !push.valid, "item pushed into a full queue")
  `GQI_ASSERT(a_no_pop_empty, qs.empty |-> !pop, "item popped from an empty queue")
endmodule

### design/gqi_back.sv
// Back end: half angles by reciprocal multiplication, quaternion update, norm,
// square root and normalization on one shared multiplier and a restoring divider.
// Depends on gqi_pkg, gqi_out_if and assert_macros.svh.
`include "assert_macros.svh"
module gqi_back (
  input  logic             clk,
  input  logic             rst,
  input  gqi_pkg::work_t   head,
  input  gqi_pkg::q_stat_t qs,
  output logic             pop,
  gqi_out_if.source        result
);
  import gqi_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE   = 16'b0000_0000_0000_0001,
    S_AMUL   = 16'b0000_0000_0000_0010,
    S_ANUM   = 16'b0000_0000_0000_0100,
    S_AEST   = 16'b0000_0000_0000_1000,
    S_AREM   = 16'b0000_0000_0001_0000,
    S_ACOR   = 16'b0000_0000_0010_0000,
    S_DIVI   = 16'b0000_0000_0100_0000,
    S_DIV    = 16'b0000_0000_1000_0000,
    S_DIVEND = 16'b0000_0001_0000_0000,
    S_RMUL   = 16'b0000_0010_0000_0000,
    S_RACC   = 16'b0000_0100_0000_0000,
    S_RND    = 16'b0000_1000_0000_0000,
    S_SQMUL  = 16'b0001_0000_0000_0000,
    S_SQACC  = 16'b0010_0000_0000_0000,
    S_SQRT   = 16'b0100_0000_0000_0000,
    S_DONE   = 16'b1000_0000_0000_0000
  } state_t;

  state_t             state;
  work_t              cur;
  logic [1:0]         idx;
  logic [1:0]         row;
  logic [1:0]         term;
  logic signed [29:0] ang [3];
  logic signed [31:0] att [4];
  logic [31:0]        qmag [4];
  logic [3:0]         qneg;
  logic [63:0]        prod;
  logic signed [63:0] acc;
  logic [63:0]        n2;
  logic [42:0]        anum;
  logic               asat;
  logic [28:0]        qest;
  logic [63:0]        rem;
  logic [63:0]        dsh;
  logic [30:0]        quo;
  logic               ovf;
  logic [4:0]         cnt;
  logic [63:0]        sq_n;
  logic [63:0]        sq_res;
  logic [63:0]        sq_bit;
  logic [31:0]        r_val;
  logic               res_valid;
  logic signed [31:0] out_q [4];

  logic signed [31:0] rate_sel;
  logic [31:0]        rate_mag;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;
  term_t              tsel;
  logic [63:0]        div_num;
  logic [31:0]        div_den;
  logic [63:0]        acc_mag;
  logic [63:0]        acc_rnd;
  logic [63:0]        n2_sum;
  logic [63:0]        sq_try;
  logic [42:0]        arem;
  logic [28:0]        ang_q;
  logic [30:0]        ang_m;
  logic [30:0]        unit_m;
  logic               out_free;

  assign pop      = (state == S_IDLE) && !qs.empty;
  assign out_free = !res_valid || result.ready;

  // Rate of the axis being worked on, and its magnitude.
  always_comb begin
    unique case (idx)
      2'd0:    rate_sel = cur.rate_x;
      2'd1:    rate_sel = cur.rate_y;
      default: rate_sel = cur.rate_z;
    endcase
    rate_mag = rate_sel[31] ? (~rate_sel + 32'd1) : rate_sel;
  end

  // Shared multiplier operands.
  always_comb begin
    tsel  = row_term(row, term);
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_AMUL: begin
        mul_a = {1'b0, rate_mag};
        mul_b = {1'b0, cur.dt_us};
      end
      S_AEST: begin
        mul_a = {1'b0, anum[42:11]};
        mul_b = {1'b0, ANGLE_RECIP};
      end
      S_AREM: begin
        mul_a = {4'b0000, qest};
        mul_b = {1'b0, ANGLE_DIV};
      end
      S_RMUL: begin
        mul_a = 33'(ang[tsel.ang_sel]);
        mul_b = 33'(att[tsel.att_sel]);
      end
      S_SQMUL: begin
        mul_a = {1'b0, qmag[idx]};
        mul_b = {1'b0, qmag[idx]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Divider inputs: rounded normalized component.
  always_comb begin
    div_num = {2'b00, qmag[idx], 30'b0} + {33'b0, r_val[31:1]};
    div_den = r_val;
  end

  // Rounding, accumulation and saturation helpers.
  always_comb begin
    acc_mag = acc[63] ? (~acc + 64'd1) : acc;
    acc_rnd = acc_mag + 64'h2000_0000;
    n2_sum  = n2 + prod;
    sq_try  = sq_res + sq_bit;
    // The quotient estimate is low by at most one; one compare fixes it.
    arem    = anum - prod[42:0];
    ang_q   = qest + {28'b0, (arem >= {11'b0, ANGLE_DIV})};
    ang_m   = asat ? ANGLE_LIMIT : {2'b00, ang_q};
    unit_m  = (ovf || quo > UNIT_LIMIT) ? UNIT_LIMIT : quo;
  end

  // Result valid: set when a result is loaded, cleared when it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Sequencer for one work item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      att[0]    <= ONE_Q30;
      att[1]    <= '0;
      att[2]    <= '0;
      att[3]    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!qs.empty) begin
            cur       <= head;
            idx       <= 2'd0;
            state     <= S_AMUL;
          end
        end
        S_AMUL: begin
          prod  <= mul_p[63:0];
          state <= S_ANUM;
        end
        S_ANUM: begin
          // Add half the divisor for rounding and flag a saturating step.
          anum  <= prod[42:0] + ANGLE_HALF[42:0];
          asat  <= prod >= ANGLE_SAT_PROD;
          state <= S_AEST;
        end
        S_AEST: begin
          qest  <= mul_p[60:32];
          state <= S_AREM;
        end
        S_AREM: begin
          prod  <= mul_p[63:0];
          state <= S_ACOR;
        end
        S_ACOR: begin
          // Half angle, clamped to a quarter radian.
          ang[idx] <= rate_sel[31] ? -$signed({1'b0, ang_m[28:0]})
                                   : $signed({1'b0, ang_m[28:0]});
          if (idx == 2'd2) begin
            row   <= 2'd0;
            term  <= 2'd0;
            acc   <= $signed({{2{att[0][31]}}, att[0], 30'b0});
            state <= S_RMUL;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_AMUL;
          end
        end
        S_DIVI: begin
          ovf   <= div_num >= {1'b0, div_den, 31'b0};
          rem   <= div_num;
          dsh   <= {2'b00, div_den, 30'b0};
          quo   <= '0;
          cnt   <= 5'd30;
          state <= S_DIV;
        end
        S_DIV: begin
          if (rem >= dsh) begin
            rem <= rem - dsh;
            quo <= {quo[29:0], 1'b1};
          end else begin
            quo <= {quo[29:0], 1'b0};
          end
          dsh <= dsh >> 1;
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) state <= S_DIVEND;
        end
        S_DIVEND: begin
          // Normalized component, clamped to one.
          att[idx] <= qneg[idx] ? -$signed({1'b0, unit_m})
                                : $signed({1'b0, unit_m});
          if (idx == 2'd3) begin
            state <= S_DONE;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_DIVI;
          end
        end
        S_RMUL: begin
          prod  <= mul_p[63:0];
          state <= S_RACC;
        end
        S_RACC: begin
          acc <= tsel.neg ? acc - $signed(prod) : acc + $signed(prod);
          if (term == 2'd2) begin
            state <= S_RND;
          end else begin
            term  <= term + 2'd1;
            state <= S_RMUL;
          end
        end
        S_RND: begin
          // Round the row back to Q2.30 as sign and magnitude.
          qmag[row] <= acc_rnd[61:30];
          qneg[row] <= acc[63];
          if (row == 2'd3) begin
            idx   <= 2'd0;
            n2    <= '0;
            state <= S_SQMUL;
          end else begin
            row   <= row + 2'd1;
            term  <= 2'd0;
            acc   <= $signed({{2{att[row + 2'd1][31]}}, att[row + 2'd1], 30'b0});
            state <= S_RMUL;
          end
        end
        S_SQMUL: begin
          prod  <= mul_p[63:0];
          state <= S_SQACC;
        end
        S_SQACC: begin
          if (idx == 2'd3) begin
            sq_n   <= n2_sum;
            sq_res <= '0;
            sq_bit <= 64'h4000_0000_0000_0000;
            cnt    <= 5'd31;
            state  <= S_SQRT;
          end else begin
            n2    <= n2_sum;
            idx   <= idx + 2'd1;
            state <= S_SQMUL;
          end
        end
        S_SQRT: begin
          // One result bit of the integer square root per cycle.
          if (sq_bit == 64'd0) begin
            r_val <= sq_res[31:0];
            if (sq_res == 64'd0) begin
              att[0] <= ONE_Q30;
              att[1] <= '0;
              att[2] <= '0;
              att[3] <= '0;
              state  <= S_DONE;
            end else begin
              idx       <= 2'd0;
              state     <= S_DIVI;
            end
          end else begin
            if (sq_n >= sq_try) begin
              sq_n   <= sq_n - sq_try;
              sq_res <= (sq_res >> 1) + sq_bit;
            end else begin
              sq_res <= sq_res >> 1;
            end
            sq_bit <= sq_bit >> 2;
            cnt    <= cnt - 5'd1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_q[0]  <= att[0];
            out_q[1]  <= att[1];
            out_q[2]  <= att[2];
            out_q[3]  <= att[3];
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid  = res_valid;
  assign result.quat_w = out_q[0];
  assign result.quat_x = out_q[1];
  assign result.quat_y = out_q[2];
  assign result.quat_z = out_q[3];

  `GQI_ASSERT(a_att_unit, (att[0] <= ONE_Q30 && att[0] >= NEG_ONE_Q30 && att[3] <= ONE_Q30 && att[3] >= NEG_ONE_Q30), "attitude component beyond one")
  `GQI_ASSERT(a_sqrt_bit, (state == S_SQRT) |-> $onehot0(sq_bit), "square root bit not a single bit")
  `GQI_ASSERT_ALWAYS(a_rst_quiet, $past(rst) |-> !res_valid, "result valid right after reset")
endmodule

### bench/gqi_attitude_checker.sv
// Watches both channels of the gyro quaternion integrator, predicts each attitude
// update and compares it with the result. Depends on gqi_in_if and gqi_out_if.
`timescale 1ns / 100ps

module gqi_attitude_checker (
  input  logic clk,
  input  logic rst,
  gqi_in_if    sample,
  gqi_out_if   result,
  output int   errors,
  output int   pending
);

  localparam longint Q30_ONE     = 64'sd1 << 30;
  localparam longint ANGLE_CLAMP = 64'sd1 << 28;

  typedef struct {
    logic signed [31:0] w;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } quat_t;

  // Predicted attitude state and the queue of attitudes still to come out.
  longint      att_q[4];
  logic [31:0] prev_time_us;
  quat_t       expected_quats[$];

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  // Division rounded to nearest, ties away from zero.
  function automatic longint div_round_away(longint num, longint unsigned den);
    longint unsigned m;
    m = (magnitude(num) + den / 2) / den;
    return (num < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Half-angle in Q2.30 from a Q8.24 rate and an elapsed time in microseconds.
  function automatic longint half_angle(logic signed [31:0] rate, logic [31:0] dt_us);
    longint          r;
    longint unsigned m;
    r = rate;
    m = (magnitude(r) * longint'({32'd0, dt_us}) + 64'd15625) / 64'd31250;
    if (m > ANGLE_CLAMP) m = ANGLE_CLAMP;
    return (r < 0) ? -longint'(m) : longint'(m);
  endfunction

  // Applies one sample to the predicted attitude and returns the new attitude.
  function automatic quat_t integrate_sample(logic signed [31:0] rx, logic signed [31:0] ry,
                                             logic signed [31:0] rz, logic [31:0] t_us);
    logic [31:0]     dt_us;
    longint          ax, ay, az, w, x, y, z, v;
    longint          acc[4];
    longint          qn[4];
    longint unsigned n2, r;
    quat_t           q;
    dt_us = t_us - prev_time_us;
    ax = half_angle(rx, dt_us);
    ay = half_angle(ry, dt_us);
    az = half_angle(rz, dt_us);
    w = att_q[0]; x = att_q[1]; y = att_q[2]; z = att_q[3];
    acc[0] = w * Q30_ONE - ax * x - ay * y - az * z;
    acc[1] = x * Q30_ONE + ax * w + az * y - ay * z;
    acc[2] = y * Q30_ONE + ay * w - az * x + ax * z;
    acc[3] = z * Q30_ONE + az * w + ay * x - ax * y;
    n2 = 0;
    for (int i = 0; i < 4; i++) begin
      qn[i] = div_round_away(acc[i], Q30_ONE);
      n2 = n2 + magnitude(qn[i]) * magnitude(qn[i]);
    end
    r = int_sqrt(n2);
    // A zero-length quaternion falls back to the identity.
    if (r == 0) begin
      att_q[0] = Q30_ONE; att_q[1] = 0; att_q[2] = 0; att_q[3] = 0;
    end else begin
      for (int i = 0; i < 4; i++) begin
        v = div_round_away(qn[i] * Q30_ONE, r);
        if (v > Q30_ONE) v = Q30_ONE;
        if (v < -Q30_ONE) v = -Q30_ONE;
        att_q[i] = v;
      end
    end
    prev_time_us = t_us;
    q.w = att_q[0][31:0]; q.x = att_q[1][31:0];
    q.y = att_q[2][31:0]; q.z = att_q[3][31:0];
    return q;
  endfunction

  initial begin
    errors  = 0;
    pending = 0;
    att_q[0] = Q30_ONE; att_q[1] = 0; att_q[2] = 0; att_q[3] = 0;
    prev_time_us = '0;
  end

  // Predict on each accepted sample, compare on each accepted result.
  always @(posedge clk) begin
    quat_t exp_q;
    if (!rst) begin
      if (sample.valid && sample.ready)
        expected_quats.push_back(integrate_sample(sample.rate_x, sample.rate_y,
                                                  sample.rate_z, sample.sample_time_us));
      if (result.valid && result.ready) begin
        if (expected_quats.size() == 0) begin
          $error("result item with no expected attitude waiting");
          errors++;
        end else begin
          exp_q = expected_quats.pop_front();
          if (result.quat_w !== exp_q.w) begin
            $error("quat_w expected %0d actual %0d", exp_q.w, result.quat_w);
            errors++;
          end
          if (result.quat_x !== exp_q.x) begin
            $error("quat_x expected %0d actual %0d", exp_q.x, result.quat_x);
            errors++;
          end
          if (result.quat_y !== exp_q.y) begin
            $error("quat_y expected %0d actual %0d", exp_q.y, result.quat_y);
            errors++;
          end
          if (result.quat_z !== exp_q.z) begin
            $error("quat_z expected %0d actual %0d", exp_q.z, result.quat_z);
            errors++;
          end
        end
      end
    end
    pending = expected_quats.size();
  end

endmodule

### bench/gyro_quaternion_integrator_test.sv
// Top of the gyro quaternion integrator bench: clock, reset, sample stimulus,
// result back-pressure and the verdict. Depends on gqi_in_if, gqi_out_if,
// gyro_quaternion_integrator and gqi_attitude_checker.
`timescale 1ns / 100ps

module gyro_quaternion_integrator_test;

  localparam int RANDOM_ITEMS = 680;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int HOLD_START   = 20_000;
  localparam int HOLD_CYCLES  = 4_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int          errors;
  int          pending;
  int          cycle_count = 0;
  logic [31:0] now_us = '0;

  gqi_in_if  sample();
  gqi_out_if result();

  gyro_quaternion_integrator u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .result (result)
  );

  gqi_attitude_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample),
    .result  (result),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offers one sample and holds it until accepted; a gap lowers valid afterward.
  task automatic offer_sample(input logic signed [31:0] rx, input logic signed [31:0] ry,
                              input logic signed [31:0] rz, input logic [31:0] t_us,
                              input int gap);
    sample.valid          <= 1'b1;
    sample.rate_x         <= rx;
    sample.rate_y         <= ry;
    sample.rate_z         <= rz;
    sample.sample_time_us <= t_us;
    do @(posedge clk); while (!sample.ready);
    if (gap > 0) begin
      sample.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] random_rate();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      2:       return $signed($urandom_range(0, 32'h0001_0000)) - 32'sh0000_8000;
      3:       return 32'sh0;
      default: return $signed($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000;
    endcase
  endfunction

  // Advances the running timestamp; mostly small steps, sometimes odd ones.
  function automatic logic [31:0] next_time(logic [31:0] t_us);
    case ($urandom_range(0, 19))
      0:       return t_us;
      1:       return $urandom();
      2:       return t_us - $urandom_range(1, 1000);
      3:       return t_us + $urandom_range(100_000, 5_000_000);
      default: return t_us + $urandom_range(1, 3000);
    endcase
  endfunction

  // Sample stimulus: directed cases, then random bursts.
  initial begin
    int burst_left;
    int gap;
    sample.valid          <= 1'b0;
    sample.rate_x         <= '0;
    sample.rate_y         <= '0;
    sample.rate_z         <= '0;
    sample.sample_time_us <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Zero dt from reset only renormalizes.
    offer_sample(32'sh0100_0000, 32'sh0, 32'sh0, 32'd0, 0);
    offer_sample(32'sh0100_0000, 32'sh0080_0000, -32'sh0040_0000, 32'd1000, 0);
    offer_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'd1500, 2);
    offer_sample(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'd2000, 0);
    offer_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, 32'd2001, 0);
    // Repeated timestamp.
    offer_sample(32'sh1234_5678, -32'sh0123_4567, 32'sh0765_4321, 32'd2001, 0);
    offer_sample(32'sh0, 32'sh0, 32'sh0, 32'd9000, 1);
    offer_sample(-32'sh0100_0000, 32'sh0, 32'sh0100_0000, 32'd10_000, 0);
    // Large step: every half-angle saturates.
    offer_sample(32'sh0200_0000, -32'sh0300_0000, 32'sh0100_0000, 32'd1_000_000, 0);
    offer_sample(32'sh0000_0001, -32'sh0000_0001, 32'sh0000_0001, 32'd1_031_250, 0);
    offer_sample(32'sh0, 32'sh7FFF_FFFF, 32'sh0, 32'hFFFF_FF00, 0);
    // Timestamp wrapping forward through zero, then one going backward.
    offer_sample(32'sh0040_0000, 32'sh0040_0000, 32'sh0040_0000, 32'h0000_0100, 3);
    offer_sample(32'sh0040_0000, -32'sh0040_0000, 32'sh0040_0000, 32'h0000_0080, 0);
    offer_sample(32'shFFFF_FFFF, 32'sh0000_0001, 32'shAAAA_AAAA, 32'h5555_5555, 0);
    offer_sample(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'hAAAA_AAAA, 0);
    offer_sample(32'sh0, 32'sh0, 32'sh0, 32'hFFFF_FFFF, 0);
    offer_sample(32'sh0300_0000, 32'sh0, 32'sh0, 32'h0000_03E7, 0);
    now_us = 32'h0000_03E7;

    // Let every result drain once before the random part.
    sample.valid <= 1'b0;
    while (pending != 0) @(posedge clk);

    burst_left = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      now_us = next_time(now_us);
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 400);
      end else begin
        gap = 0;
      end
      burst_left--;
      if (burst_left != 0) gap = 0;
      offer_sample(random_rate(), random_rate(), random_rate(), now_us, gap);
      // Once midway, hold back until the block has emptied.
      if (i == RANDOM_ITEMS / 2) begin
        sample.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
    end
    sample.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Result back-pressure: stall patterns, plus one long hold-off.
  initial begin
    int held;
    int phase_left;
    int mode;
    result.ready <= 1'b0;
    @(negedge rst);
    phase_left = 0;
    mode = 0;
    held = 0;
    forever begin
      @(posedge clk);
      if (cycle_count >= HOLD_START && held < HOLD_CYCLES) begin
        held++;
        result.ready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(50, 3000);
          mode = $urandom_range(0, 2);
        end
        phase_left--;
        case (mode)
          0:       result.ready <= 1'b1;
          1:       result.ready <= ($urandom_range(0, 3) != 0);
          default: result.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

endmodule

### sim.f
+incdir+design
design/gqi_pkg.sv
design/gqi_in_if.sv
design/gqi_out_if.sv
design/gqi_front.sv
design/gqi_queue.sv
design/gqi_back.sv
design/gyro_quaternion_integrator.sv
bench/gqi_attitude_checker.sv
bench/gyro_quaternion_integrator_test.sv
